>>> src/ssh_pkg.sv
// shared types and constants for the space-saving heavy-hitter tracker
// no dependencies
`default_nettype none

package ssh_pkg;

    localparam int KEY_BITS     = 64;
    localparam int SLOT_BITS    = 4;
    localparam int OUT_CNT_BITS = 32;
    localparam int OUT_OCC_BITS = 5;
    localparam int TOPN_BITS    = 5;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DAT_BITS = 5;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SAMPLER_ENABLE = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TOP_N          = 1'd1;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    typedef enum logic [2:0] {
        OC_HIT     = 3'd0,
        OC_INSERT  = 3'd1,
        OC_REPLACE = 3'd2,
        OC_IGNORED = 3'd3,
        OC_READ    = 3'd4
    } t_outcome;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_READ_WAIT,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rd_slot;
        logic rd_scan;
        logic emit_ignored;
        logic emit_read;
        logic update;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic action;
        logic enable;
        logic occ_zero;
        logic scan_last;
    } t_stat;

endpackage

`default_nettype wire

>>> src/ssh_ram.sv
// generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none

module ssh_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> src/ssh_ctrl.sv
// controller state machine: sequences read, scan and update of one request
// depends on ssh_pkg
`default_nettype none

module ssh_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire ssh_pkg::t_stat i_stat,
    output ssh_pkg::t_cmd      o_cmd,
    output logic               o_busy
);

    ssh_pkg::t_state r_state;
    ssh_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssh_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            ssh_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    priority if (i_stat.action == ssh_pkg::ACT_READ) begin
                        n_state = ssh_pkg::ST_READ;
                    end else if (!i_stat.enable) begin
                        o_cmd.emit_ignored = 1'b1;
                    end else if (i_stat.occ_zero) begin
                        n_state = ssh_pkg::ST_UPDATE;
                    end else begin
                        n_state = ssh_pkg::ST_SCAN;
                    end
                end
            end
            ssh_pkg::ST_READ: begin
                o_cmd.rd_slot = 1'b1;
                n_state = ssh_pkg::ST_READ_WAIT;
            end
            ssh_pkg::ST_READ_WAIT: begin
                o_cmd.emit_read = 1'b1;
                n_state = ssh_pkg::ST_IDLE;
            end
            ssh_pkg::ST_SCAN: begin
                o_cmd.rd_scan = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = ssh_pkg::ST_DRAIN;
                end
            end
            ssh_pkg::ST_DRAIN: begin
                // last read data is compared here
                n_state = ssh_pkg::ST_UPDATE;
            end
            ssh_pkg::ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state = ssh_pkg::ST_IDLE;
            end
            default: begin
                n_state = ssh_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/ssh_datapath.sv
// datapath: entry table RAM, scan compare and minimum tracking, update, result register
// depends on ssh_pkg and ssh_ram
`default_nettype none

module ssh_datapath #(
    parameter int TABLE_ENTRIES = 16,
    parameter int COUNT_BITS    = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire ssh_pkg::t_cmd                      i_cmd,
    output ssh_pkg::t_stat                          o_stat,
    input  wire logic                               i_action,
    input  wire logic [ssh_pkg::KEY_BITS-1:0]       i_key_hash,
    input  wire logic [ssh_pkg::SLOT_BITS-1:0]      i_slot_index,
    input  wire logic                               i_cfg_valid,
    input  wire logic [ssh_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  wire logic [ssh_pkg::CFG_DAT_BITS-1:0]   i_cfg_data,
    output logic                                    o_valid,
    output logic [2:0]                              o_outcome,
    output logic [ssh_pkg::SLOT_BITS-1:0]           o_slot,
    output logic [ssh_pkg::KEY_BITS-1:0]            o_entry_key,
    output logic [ssh_pkg::OUT_CNT_BITS-1:0]        o_entry_count,
    output logic                                    o_entry_valid,
    output logic [ssh_pkg::OUT_OCC_BITS-1:0]        o_occupied
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int OW = $clog2(TABLE_ENTRIES + 1);
    localparam int CW = (OW > ssh_pkg::TOPN_BITS) ? OW : ssh_pkg::TOPN_BITS;
    localparam int SW = (AW > ssh_pkg::SLOT_BITS) ? AW : ssh_pkg::SLOT_BITS;
    localparam int DW = ssh_pkg::KEY_BITS + COUNT_BITS;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        if (&c) begin
            return c;
        end
        return c + COUNT_BITS'(1);
    endfunction

    function automatic logic [ssh_pkg::OUT_CNT_BITS-1:0] cnt_out(
        input logic [COUNT_BITS-1:0] c
    );
        logic [63:0] w;
        w = 64'(c);
        return w[ssh_pkg::OUT_CNT_BITS-1:0];
    endfunction

    function automatic logic [ssh_pkg::SLOT_BITS-1:0] slot_out(input logic [AW-1:0] a);
        logic [SW-1:0] w;
        w = SW'(a);
        return w[ssh_pkg::SLOT_BITS-1:0];
    endfunction

    // configuration
    logic                          r_sampler_enable;
    logic [ssh_pkg::TOPN_BITS-1:0] r_top_n;

    // table state and latched request
    logic [OW-1:0]                 r_occ;
    logic [ssh_pkg::KEY_BITS-1:0]  r_key;
    logic [ssh_pkg::SLOT_BITS-1:0] r_slot_sel;

    // scan state
    logic [AW-1:0]         r_idx;
    logic                  r_cmp_vld;
    logic [AW-1:0]         r_cmp_idx;
    logic                  r_hit;
    logic [AW-1:0]         r_hit_idx;
    logic [COUNT_BITS-1:0] r_hit_cnt;
    logic [AW-1:0]         r_min_idx;
    logic [COUNT_BITS-1:0] r_min_cnt;

    // RAM ports
    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    logic [DW-1:0]                rd_data;
    logic [ssh_pkg::KEY_BITS-1:0] rd_key;
    logic [COUNT_BITS-1:0]        rd_cnt;
    logic [AW-1:0]                wr_addr;
    logic [DW-1:0]                wr_data;

    logic [CW-1:0]         occ_ext;
    logic [CW-1:0]         top_ext;
    logic [CW-1:0]         limit;
    logic [SW-1:0]         slot_ext;
    logic                  rd_ok;
    logic [AW-1:0]         upd_idx;
    logic [COUNT_BITS-1:0] upd_cnt;
    ssh_pkg::t_outcome     upd_outcome;
    logic                  upd_insert;
    logic [CW-1:0]         upd_occ;

    ssh_ram #(
        .WIDTH(DW),
        .DEPTH(TABLE_ENTRIES),
        .AW   (AW)
    ) u_table (
        .i_clk    (i_clk),
        .i_wr_en  (i_cmd.update),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    always_comb begin
        rd_key   = rd_data[DW-1:COUNT_BITS];
        rd_cnt   = rd_data[COUNT_BITS-1:0];
        slot_ext = SW'(r_slot_sel);
        rd_en    = i_cmd.rd_scan | i_cmd.rd_slot;
        rd_addr  = i_cmd.rd_slot ? slot_ext[AW-1:0] : r_idx;

        occ_ext = CW'(r_occ);
        top_ext = CW'(r_top_n);
        // top_n clamped to one .. table size
        priority if (top_ext == '0) begin
            limit = CW'(1);
        end else if (top_ext > CW'(TABLE_ENTRIES)) begin
            limit = CW'(TABLE_ENTRIES);
        end else begin
            limit = top_ext;
        end

        // entries at or beyond occupancy (and beyond the table) read as empty
        rd_ok = CW'(r_slot_sel) < occ_ext;

        upd_insert = 1'b0;
        priority if (r_hit) begin
            upd_idx     = r_hit_idx;
            upd_cnt     = sat_inc(r_hit_cnt);
            upd_outcome = ssh_pkg::OC_HIT;
        end else if (occ_ext < limit) begin
            upd_idx     = r_occ[AW-1:0];
            upd_cnt     = COUNT_BITS'(1);
            upd_outcome = ssh_pkg::OC_INSERT;
            upd_insert  = 1'b1;
        end else begin
            upd_idx     = r_min_idx;
            upd_cnt     = sat_inc(r_min_cnt);
            upd_outcome = ssh_pkg::OC_REPLACE;
        end
        upd_occ = upd_insert ? occ_ext + CW'(1) : occ_ext;
        wr_addr = upd_idx;
        wr_data = {r_key, upd_cnt};

        o_stat.action    = i_action;
        o_stat.enable    = r_sampler_enable;
        o_stat.occ_zero  = (r_occ == '0);
        o_stat.scan_last = (CW'(r_idx) + CW'(1)) == occ_ext;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sampler_enable <= 1'b1;
            r_top_n          <= ssh_pkg::TOPN_BITS'(16);
            r_occ            <= '0;
            r_cmp_vld        <= 1'b0;
            r_hit            <= 1'b0;
            r_idx            <= '0;
            o_valid          <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    ssh_pkg::CFG_SAMPLER_ENABLE: r_sampler_enable <= i_cfg_data[0];
                    ssh_pkg::CFG_TOP_N:          r_top_n <= i_cfg_data;
                    default: ;
                endcase
            end
            r_cmp_vld <= i_cmd.rd_scan;
            o_valid   <= i_cmd.emit_ignored | i_cmd.emit_read | i_cmd.update;
            if (i_cmd.load) begin
                r_idx <= '0;
                r_hit <= 1'b0;
            end else begin
                if (i_cmd.rd_scan) begin
                    r_idx <= r_idx + AW'(1);
                end
                if (r_cmp_vld && !r_hit && rd_key == r_key) begin
                    r_hit <= 1'b1;
                end
            end
            if (i_cmd.update) begin
                r_occ <= upd_occ[OW-1:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key      <= i_key_hash;
            r_slot_sel <= i_slot_index;
        end
        r_cmp_idx <= r_idx;
        if (r_cmp_vld) begin
            if (!r_hit && rd_key == r_key) begin
                r_hit_idx <= r_cmp_idx;
                r_hit_cnt <= rd_cnt;
            end
            // strict less keeps the lowest index on a tie
            if (r_cmp_idx == '0 || rd_cnt < r_min_cnt) begin
                r_min_idx <= r_cmp_idx;
                r_min_cnt <= rd_cnt;
            end
        end
        if (i_cmd.emit_ignored) begin
            o_outcome     <= ssh_pkg::OC_IGNORED;
            o_slot        <= '0;
            o_entry_key   <= '0;
            o_entry_count <= '0;
            o_entry_valid <= 1'b0;
            o_occupied    <= occ_ext[ssh_pkg::OUT_OCC_BITS-1:0];
        end else if (i_cmd.emit_read) begin
            o_outcome     <= ssh_pkg::OC_READ;
            o_slot        <= r_slot_sel;
            o_entry_key   <= rd_ok ? rd_key : '0;
            o_entry_count <= rd_ok ? cnt_out(rd_cnt) : '0;
            o_entry_valid <= rd_ok;
            o_occupied    <= occ_ext[ssh_pkg::OUT_OCC_BITS-1:0];
        end else if (i_cmd.update) begin
            o_outcome     <= upd_outcome;
            o_slot        <= slot_out(upd_idx);
            o_entry_key   <= r_key;
            o_entry_count <= cnt_out(upd_cnt);
            o_entry_valid <= 1'b1;
            o_occupied    <= upd_occ[ssh_pkg::OUT_OCC_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

>>> src/space_saving_heavy_hitters.sv
// Space-Saving top-K heavy-hitter tracker over 64-bit key hashes.
// Request channel: i_start with i_action/i_key_hash/i_slot_index is taken at a
// clock edge where i_start is high and o_busy is low. Action 0 samples a key,
// action 1 reads one table entry.
// Result channel: o_valid is high for one cycle with the outcome, slot, entry
// key, count, valid flag and occupancy; the receiver cannot stall it.
// Configuration: i_cfg_valid/o_cfg_ready write register i_cfg_index
// (0 sampler_enable, 1 top_n) with i_cfg_data; o_cfg_ready is always high.
// Sequencing: an ignored sample gives its result in the next cycle and
// o_busy stays low. A read keeps the block busy in ST_READ and ST_READ_WAIT,
// with the result registered from ST_READ_WAIT. A sample scans the occupied
// entries through the table RAM read port one entry per cycle, then passes
// ST_DRAIN and ST_UPDATE (an empty table goes straight to ST_UPDATE).
// Reset (synchronous, active low) empties the table, enables sampling and
// sets top_n to 16; no clearing pass is needed.
// depends on ssh_pkg, ssh_ctrl, ssh_datapath, ssh_ram
`default_nettype none

module space_saving_heavy_hitters #(
    parameter int TABLE_ENTRIES = 16,
    parameter int COUNT_BITS    = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    output logic                                  o_busy,
    input  wire logic                             i_action,
    input  wire logic [ssh_pkg::KEY_BITS-1:0]     i_key_hash,
    input  wire logic [ssh_pkg::SLOT_BITS-1:0]    i_slot_index,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [ssh_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [ssh_pkg::CFG_DAT_BITS-1:0] i_cfg_data,
    output logic                                  o_valid,
    output logic [2:0]                            o_outcome,
    output logic [ssh_pkg::SLOT_BITS-1:0]         o_slot,
    output logic [ssh_pkg::KEY_BITS-1:0]          o_entry_key,
    output logic [ssh_pkg::OUT_CNT_BITS-1:0]      o_entry_count,
    output logic                                  o_entry_valid,
    output logic [ssh_pkg::OUT_OCC_BITS-1:0]      o_occupied
);

    ssh_pkg::t_cmd  cmd;
    ssh_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    ssh_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_stat (stat),
        .o_cmd  (cmd),
        .o_busy (o_busy)
    );

    ssh_datapath #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .COUNT_BITS   (COUNT_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_action     (i_action),
        .i_key_hash   (i_key_hash),
        .i_slot_index (i_slot_index),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .o_outcome    (o_outcome),
        .o_slot       (o_slot),
        .o_entry_key  (o_entry_key),
        .o_entry_count(o_entry_count),
        .o_entry_valid(o_entry_valid),
        .o_occupied   (o_occupied)
    );

endmodule

`default_nettype wire
